// ===== hw/rtl/svp_pkg.sv =====
// Shared types and constants for the servo pulse block.
// Used by svp_front, svp_fifo, svp_back and the top level.
package svp_pkg;

  localparam int WINDOW_DEF = 8;
  localparam int SAMPLE_W   = 12;
  localparam int REG_W      = 15;
  localparam int PULSE_W    = 15;
  localparam int DUTY_W     = 15;
  localparam int FIFO_DEPTH = 2;

  localparam logic [REG_W-1:0] PULSE_MIN_RST = 15'd500;
  localparam logic [REG_W-1:0] PULSE_MAX_RST = 15'd2500;
  localparam logic [REG_W-1:0] DEAD_BAND_RST = 15'd10;
  localparam logic [REG_W-1:0] PULSE_LIMIT   = 15'd20000;
  localparam logic [REG_W-1:0] DUTY_LIMIT    = 15'd16384;

  // average * span < 2^27, reciprocal of 4095 scaled by 2^27
  localparam int MAP_K = 27;
  localparam logic [15:0] MAP_RECIP = 16'd32776;
  localparam logic [15:0] ADC_FULL  = 16'd4095;

  // duty = width * 512 / 625, reciprocal of 625 scaled by 2^24
  localparam int DUTY_K = 24;
  localparam logic [15:0] DUTY_RECIP = 16'd26843;
  localparam logic [15:0] DUTY_DIV   = 16'd625;

  localparam int ADDR_W = 4;
  typedef enum logic [1:0] {
    REG_PULSE_MIN = 2'd0,
    REG_PULSE_MAX = 2'd1,
    REG_DEAD_BAND = 2'd2
  } reg_idx_t;

  typedef enum logic [0:0] {
    F_IDLE,
    F_SUM
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_AVG_MUL,
    B_AVG_EST,
    B_AVG_FIX,
    B_MAP_MUL,
    B_MAP_EST,
    B_MAP_FIX,
    B_DUTY_MUL,
    B_DUTY_EST,
    B_DUTY_FIX,
    B_DUTY_OUT
  } back_state_t;

  typedef struct packed {
    logic [REG_W-1:0] pulse_min;
    logic [REG_W-1:0] pulse_max;
    logic [REG_W-1:0] dead_band;
  } cfg_regs_t;

endpackage

// ===== hw/rtl/svp_front.sv =====
// Front end: accepts samples, keeps the sample ring and the running sum.
// Pushes each new ring sum into the queue. Depends on svp_pkg.
module svp_front import svp_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  parameter int SUM_W  = $clog2(WINDOW * 4095 + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                push,
  output logic [SUM_W-1:0]    push_sum,
  input  logic                q_full
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [SAMPLE_W-1:0] ring_mem [WINDOW];

  front_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic                wrapped_r, wrapped_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] smp_r;
  logic [SAMPLE_W-1:0] old_r;
  logic                old_vld_r;
  logic                accept;

  assign accept   = in_valid && in_ready;
  assign push_sum = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      slot_r    <= '0;
      wrapped_r <= 1'b0;
      sum_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      slot_r    <= slot_nxt;
      wrapped_r <= wrapped_nxt;
      sum_r     <= push ? sum_nxt : sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r     <= in_sample;
      old_r     <= ring_mem[slot_r];
      old_vld_r <= wrapped_r;
    end
    if (push) begin
      ring_mem[slot_r] <= smp_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    wrapped_nxt = wrapped_r;
    in_ready    = 1'b0;
    push        = 1'b0;
    sum_nxt     = SUM_W'(sum_r - SUM_W'(old_vld_r ? old_r : '0) + SUM_W'(smp_r));
    case (state_r)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = F_SUM;
        end
      end
      F_SUM: begin
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
          if (slot_r == IDX_W'(WINDOW - 1)) begin
            slot_nxt    = '0;
            wrapped_nxt = 1'b1;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/svp_fifo.sv =====
// Short queue of ring sums between front and back.
// Depends on svp_pkg for the default depth.
module svp_fifo import svp_pkg::*; #(
  parameter int WIDTH = 15,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] q_mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/svp_back.sv =====
// Back end: average, pulse mapping, dead band and duty on one shared
// multiplier, plus the result register. Depends on svp_pkg.
module svp_back import svp_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  parameter int SUM_W  = $clog2(WINDOW * 4095 + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_regs_t           cfg,
  input  logic [SUM_W-1:0]    q_sum,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_updated,
  output logic [DUTY_W-1:0]   out_duty,
  output logic [PULSE_W-1:0]  out_pulse,
  output logic [SAMPLE_W-1:0] out_average
);

  localparam int MA_W = (SUM_W > MAP_K) ? SUM_W : MAP_K;
  localparam int MB_W = (SUM_W + 1 > 16) ? SUM_W + 1 : 16;
  localparam int MP_W = MA_W + MB_W;
  localparam logic [MB_W-1:0] AVG_RECIP = MB_W'((64'd1 << SUM_W) / WINDOW);

  back_state_t         state_r, state_nxt;
  logic [MP_W-1:0]     mul_r;
  logic [MA_W-1:0]     mul_a;
  logic [MB_W-1:0]     mul_b;

  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] est_r;
  logic [SAMPLE_W-1:0] avg_r;
  logic [MAP_K-1:0]    prod_r;
  logic [PULSE_W-1:0]  qe_r;
  logic [DUTY_W-1:0]   qd_r;
  logic [PULSE_W-1:0]  last_r, last_nxt;
  logic                upd_r, upd_nxt;

  logic                ov_r, ov_nxt;
  logic                ou_r;
  logic [DUTY_W-1:0]   od_r;
  logic [PULSE_W-1:0]  op_r;
  logic [SAMPLE_W-1:0] oa_r;

  logic signed [PULSE_W:0] span;
  logic                    span_neg;
  logic [PULSE_W-1:0]      span_abs;
  logic [SUM_W-1:0]        avg_rem;
  logic [MAP_K-1:0]        map_rem;
  logic [PULSE_W:0]        map_q;
  logic [PULSE_W:0]        width_raw;
  logic [PULSE_W-1:0]      width;
  logic [PULSE_W-1:0]      diff;
  logic [DUTY_K-1:0]       duty_y;
  logic [DUTY_K-1:0]       duty_rem;
  logic [DUTY_W-1:0]       duty;
  logic                    load_out;

  assign out_valid   = ov_r;
  assign out_updated = ou_r;
  assign out_duty    = od_r;
  assign out_pulse   = op_r;
  assign out_average = oa_r;

  assign span     = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});
  assign span_neg = span[PULSE_W];
  assign span_abs = span_neg ? PULSE_W'(-span) : PULSE_W'(span);

  assign avg_rem   = sum_r - mul_r[SUM_W-1:0];
  assign map_rem   = prod_r - mul_r[MAP_K-1:0];
  assign map_q     = {1'b0, qe_r} + ((map_rem >= MAP_K'(ADC_FULL)) ? 1'b1 : 1'b0);
  assign width_raw = span_neg ? ({1'b0, cfg.pulse_min} - map_q)
                              : ({1'b0, cfg.pulse_min} + map_q);
  assign width     = (width_raw > {1'b0, PULSE_LIMIT}) ? PULSE_LIMIT
                                                       : width_raw[PULSE_W-1:0];
  assign diff      = (width > last_r) ? (width - last_r) : (last_r - width);
  assign duty_y    = {last_r, 9'b0};
  assign duty_rem  = duty_y - mul_r[DUTY_K-1:0];
  assign duty      = qd_r + ((duty_rem >= DUTY_K'(DUTY_DIV)) ? 1'b1 : 1'b0);

  always_ff @(posedge clk) begin
    mul_r <= MP_W'(mul_a) * MP_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      last_r  <= PULSE_MIN_RST;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    upd_r <= upd_nxt;
    case (state_r)
      B_IDLE:     sum_r  <= q_sum;
      B_AVG_EST:  est_r  <= mul_r[SUM_W +: SAMPLE_W];
      B_AVG_FIX:  avg_r  <= est_r + ((avg_rem >= SUM_W'(WINDOW)) ? 1'b1 : 1'b0);
      B_MAP_EST:  prod_r <= mul_r[MAP_K-1:0];
      B_MAP_FIX:  qe_r   <= mul_r[MAP_K +: PULSE_W];
      B_DUTY_FIX: qd_r   <= mul_r[DUTY_K +: DUTY_W];
      default: ;
    endcase
    if (load_out) begin
      ou_r <= upd_r;
      od_r <= duty;
      op_r <= last_r;
      oa_r <= avg_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    upd_nxt   = upd_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    ov_nxt    = ov_r && !out_ready;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_AVG_MUL;
        end
      end
      B_AVG_MUL: begin
        mul_a     = MA_W'(sum_r);
        mul_b     = AVG_RECIP;
        state_nxt = B_AVG_EST;
      end
      B_AVG_EST: begin
        mul_a     = MA_W'(mul_r[SUM_W +: SAMPLE_W]);
        mul_b     = MB_W'(WINDOW);
        state_nxt = B_AVG_FIX;
      end
      B_AVG_FIX: begin
        state_nxt = B_MAP_MUL;
      end
      B_MAP_MUL: begin
        mul_a     = MA_W'(avg_r);
        mul_b     = MB_W'(span_abs);
        state_nxt = B_MAP_EST;
      end
      B_MAP_EST: begin
        mul_a     = MA_W'(mul_r[MAP_K-1:0]);
        mul_b     = MB_W'(MAP_RECIP);
        state_nxt = B_MAP_FIX;
      end
      B_MAP_FIX: begin
        mul_a     = MA_W'(mul_r[MAP_K +: PULSE_W]);
        mul_b     = MB_W'(ADC_FULL);
        state_nxt = B_DUTY_MUL;
      end
      B_DUTY_MUL: begin
        upd_nxt = (diff > cfg.dead_band);
        if (diff > cfg.dead_band) begin
          last_nxt = width;
        end
        state_nxt = B_DUTY_EST;
      end
      B_DUTY_EST: begin
        mul_a     = MA_W'(duty_y);
        mul_b     = MB_W'(DUTY_RECIP);
        state_nxt = B_DUTY_FIX;
      end
      B_DUTY_FIX: begin
        mul_a     = MA_W'(mul_r[DUTY_K +: DUTY_W]);
        mul_b     = MB_W'(DUTY_DIV);
        state_nxt = B_DUTY_OUT;
      end
      B_DUTY_OUT: begin
        mul_a = MA_W'(qd_r);
        mul_b = MB_W'(DUTY_DIV);
        if (!ov_r || out_ready) begin
          load_out  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/servo_pulse_from_filtered_adc.sv =====
// Servo pulse from filtered ADC: top level with APB registers and assertions.
// A request is registered in the front end and pushed into the queue as a ring sum;
// the back end takes one sum at a time, stepping every average, map and duty
// product through one shared multiplier, and stalls while out_tready is low on a held result.
// Reset (sync, active low): sum and ring wrap flag cleared, last pulse set to 500 us,
// registers at 500 / 2500 / 10; no clearing pass, inputs taken at once.
module servo_pulse_from_filtered_adc import svp_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [11:0] sample
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // [0] updated, [15:1] duty, [30:16] pulse_us,
                                        // [42:31] average
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int SUM_W = $clog2(WINDOW * 4095 + 1);

  cfg_regs_t           cfg_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  logic                push;
  logic [SUM_W-1:0]    push_sum;
  logic                pop;
  logic [SUM_W-1:0]    pop_sum;
  logic                q_full;
  logic                q_empty;

  logic                res_upd;
  logic [DUTY_W-1:0]   res_duty;
  logic [PULSE_W-1:0]  res_pulse;
  logic [SAMPLE_W-1:0] res_avg;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_min <= PULSE_MIN_RST;
      cfg_r.pulse_max <= PULSE_MAX_RST;
      cfg_r.dead_band <= DEAD_BAND_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PULSE_MIN: cfg_r.pulse_min <= cfg_pwdata[REG_W-1:0];
        REG_PULSE_MAX: cfg_r.pulse_max <= cfg_pwdata[REG_W-1:0];
        REG_DEAD_BAND: cfg_r.dead_band <= cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PULSE_MIN: cfg_prdata = 32'(cfg_r.pulse_min);
      REG_PULSE_MAX: cfg_prdata = 32'(cfg_r.pulse_max);
      REG_DEAD_BAND: cfg_prdata = 32'(cfg_r.dead_band);
      default:       cfg_prdata = '0;
    endcase
  end

  svp_front #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .push      (push),
    .push_sum  (push_sum),
    .q_full    (q_full)
  );

  svp_fifo #(
    .WIDTH (SUM_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_sum),
    .pop       (pop),
    .pop_data  (pop_sum),
    .full      (q_full),
    .empty     (q_empty)
  );

  svp_back #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_sum       (pop_sum),
    .q_empty     (q_empty),
    .q_pop       (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_updated (res_upd),
    .out_duty    (res_duty),
    .out_pulse   (res_pulse),
    .out_average (res_avg)
  );

  assign out_tdata = {5'b0, res_avg, res_pulse, res_duty, res_upd};

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("queue push while full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("queue pop while empty");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_pulse <= PULSE_LIMIT) && (res_duty <= DUTY_LIMIT))
    else $error("pulse or duty out of range");

  a_front_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("front took a second sample before pushing the first");

endmodule
